FILE: design/ftws_pkg.sv
// Shared types and constants for the frame time window statistics block.
package ftws_pkg;

   localparam int TS_W     = 32;
   localparam int SAMPLE_W = 24;
   localparam int FPS_W    = 28;
   localparam int HELD_W   = 7;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [FPS_W-1:0]    FPS_NUM    = 28'd256000000;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_END   = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic                is_end;
      logic [SAMPLE_W-1:0] elapsed;
   } ftws_op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EVICT,
      BK_START,
      BK_RUN,
      BK_RESP
   } ftws_back_state_type;

endpackage

FILE: design/ftws_if.sv
// Request and response channel interfaces.
interface ftws_req_if;
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [ftws_pkg::TS_W-1:0] timestamp_us;

   modport source (output valid, output command, output timestamp_us, input ready);
   modport sink   (input valid, input command, input timestamp_us, output ready);
endinterface

interface ftws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ftws_pkg::SAMPLE_W-1:0] last_frame_us;
   logic [ftws_pkg::SAMPLE_W-1:0] average_frame_us;
   logic [ftws_pkg::FPS_W-1:0]    fps_q8;
   logic [ftws_pkg::SAMPLE_W-1:0] min_frame_us;
   logic [ftws_pkg::SAMPLE_W-1:0] max_frame_us;
   logic [ftws_pkg::HELD_W-1:0]   samples_held;

   modport source (output valid, output last_frame_us, output average_frame_us,
                   output fps_q8, output min_frame_us, output max_frame_us,
                   output samples_held, input ready);
   modport sink   (input valid, input last_frame_us, input average_frame_us,
                   input fps_q8, input min_frame_us, input max_frame_us,
                   input samples_held, output ready);
endinterface

FILE: design/ftws_front.sv
// Front end: accepts events, tracks frame start and measures elapsed time.
module ftws_front (
   input  logic                  clock,
   input  logic                  reset,
   ftws_req_if.sink              req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output ftws_pkg::ftws_op_type q_op
);

   logic [ftws_pkg::TS_W-1:0] frame_start_ff;
   logic [ftws_pkg::TS_W-1:0] diff;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign diff           = req_chan.timestamp_us - frame_start_ff;

   always_comb begin
      q_op.is_end  = (req_chan.command == ftws_pkg::CMD_END);
      q_op.elapsed = (|diff[ftws_pkg::TS_W-1:ftws_pkg::SAMPLE_W]) ? ftws_pkg::SAMPLE_MAX
                                                                  : diff[ftws_pkg::SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= '0;
      end else if (q_push && req_chan.command == ftws_pkg::CMD_BEGIN) begin
         frame_start_ff <= req_chan.timestamp_us;
      end
   end

endmodule

FILE: design/ftws_queue.sv
// Two-entry item queue between front and back.
module ftws_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ftws_pkg::ftws_op_type push_op,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ftws_pkg::ftws_op_type head_op
);

   ftws_pkg::ftws_op_type              entry_ff [ftws_pkg::QUEUE_DEPTH];
   logic [ftws_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [ftws_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [ftws_pkg::QUEUE_CNT_W-1:0]   count_ff;

   assign full       = (count_ff == ftws_pkg::QUEUE_CNT_W'(ftws_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: design/ftws_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ftws_div #(
   parameter int DIV_W = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIV_W-1:0]              dividend,
   input  logic [ftws_pkg::SAMPLE_W-1:0] divisor,
   output logic                          done,
   output logic [DIV_W-1:0]              quotient
);

   localparam int CntW = $clog2(DIV_W + 1);

   logic                          busy_ff;
   logic                          done_ff;
   logic [CntW-1:0]               cnt_ff;
   logic [ftws_pkg::SAMPLE_W-1:0] rem_ff;
   logic [ftws_pkg::SAMPLE_W-1:0] divisor_ff;
   logic [DIV_W-1:0]              quo_ff;
   logic [ftws_pkg::SAMPLE_W:0]   trial;
   logic [ftws_pkg::SAMPLE_W:0]   diff;
   logic                          fits;

   assign trial    = {rem_ff, quo_ff[DIV_W-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = (trial >= {1'b0, divisor_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[ftws_pkg::SAMPLE_W-1:0] : trial[ftws_pkg::SAMPLE_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

endmodule

FILE: design/ftws_back.sv
// Back end: sample ring, running sum, window scan, divides and result register.
module ftws_back #(
   parameter int WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ftws_pkg::ftws_op_type q_op,
   output logic                  q_pop,
   ftws_rsp_if.source            rsp_chan
);

   localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CntW = $clog2(WINDOW + 1);
   localparam int SumW = ftws_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int DivW = (SumW > ftws_pkg::FPS_W) ? SumW : ftws_pkg::FPS_W;
   localparam int SW   = ftws_pkg::SAMPLE_W;

   ftws_pkg::ftws_back_state_type state_ff, state_in;
   ftws_pkg::ftws_op_type         op_ff;

   logic [SW-1:0]   ring_mem [WINDOW];
   logic [SW-1:0]   rd_data_ff;
   logic [IdxW-1:0] rd_addr;

   logic [SumW-1:0] sum_ff;
   logic [IdxW-1:0] slot_ff;
   logic [CntW-1:0] fill_ff;
   logic [SW-1:0]   last_ff;

   logic [CntW-1:0] scan_cnt_ff;
   logic            scan_pend_ff;
   logic [SW-1:0]   min_ff;
   logic [SW-1:0]   max_ff;
   logic            scan_done;

   logic [SW-1:0]              avg_ff;
   logic [ftws_pkg::FPS_W-1:0] fps_ff;
   logic                       div_fps_ff;
   logic                       arith_done_ff;

   logic            div_start;
   logic [DivW-1:0] div_dividend;
   logic [SW-1:0]   div_divisor;
   logic            div_done;
   logic [DivW-1:0] div_quo;
   logic [SW-1:0]   avg_q;

   logic                        full;
   logic [SW-1:0]               old_sample;
   logic                        out_free;
   logic                        load_out;
   logic [31:0]                 held_ext;

   logic                        rsp_valid_ff;
   logic [SW-1:0]               rsp_last_ff;
   logic [SW-1:0]               rsp_avg_ff;
   logic [ftws_pkg::FPS_W-1:0]  rsp_fps_ff;
   logic [SW-1:0]               rsp_min_ff;
   logic [SW-1:0]               rsp_max_ff;
   logic [ftws_pkg::HELD_W-1:0] rsp_held_ff;

   assign full       = (fill_ff == CntW'(WINDOW));
   assign old_sample = full ? rd_data_ff : '0;
   assign scan_done  = (scan_cnt_ff == fill_ff) && !scan_pend_ff;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign avg_q      = (div_quo > DivW'(ftws_pkg::SAMPLE_MAX)) ? ftws_pkg::SAMPLE_MAX
                                                               : div_quo[SW-1:0];
   assign held_ext   = 32'(fill_ff);

   ftws_div #(.DIV_W(DivW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      rd_addr      = slot_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      load_out     = 1'b0;
      unique case (state_ff)
         ftws_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = q_op.is_end ? ftws_pkg::BK_EVICT : ftws_pkg::BK_START;
            end
         end
         ftws_pkg::BK_EVICT: begin
            state_in = ftws_pkg::BK_START;
         end
         ftws_pkg::BK_START: begin
            state_in = ftws_pkg::BK_RUN;
            if (fill_ff != '0) begin
               div_start    = 1'b1;
               div_dividend = DivW'(sum_ff);
               div_divisor  = SW'(fill_ff);
            end
         end
         ftws_pkg::BK_RUN: begin
            rd_addr = scan_cnt_ff[IdxW-1:0];
            if (div_done && !div_fps_ff && avg_q != '0) begin
               div_start    = 1'b1;
               div_dividend = DivW'(ftws_pkg::FPS_NUM);
               div_divisor  = avg_q;
            end
            if (scan_done && arith_done_ff) begin
               state_in = ftws_pkg::BK_RESP;
            end
         end
         ftws_pkg::BK_RESP: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ftws_pkg::BK_IDLE;
            end
         end
         default: state_in = ftws_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftws_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ftws_pkg::BK_EVICT) begin
         ring_mem[slot_ff] <= op_ff.elapsed;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= q_op;
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         slot_ff <= '0;
         fill_ff <= '0;
         last_ff <= '0;
      end else if (state_ff == ftws_pkg::BK_EVICT) begin
         sum_ff  <= sum_ff - SumW'(old_sample) + SumW'(op_ff.elapsed);
         slot_ff <= (slot_ff == IdxW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         fill_ff <= full ? fill_ff : fill_ff + 1'b1;
         last_ff <= op_ff.elapsed;
      end
   end

   // scan and divide sequencing
   always_ff @(posedge clock) begin
      if (state_ff == ftws_pkg::BK_START) begin
         scan_cnt_ff  <= '0;
         scan_pend_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         div_fps_ff   <= 1'b0;
         if (fill_ff != '0) begin
            arith_done_ff <= 1'b0;
         end else begin
            arith_done_ff <= 1'b1;
            avg_ff        <= '0;
            fps_ff        <= '0;
         end
      end else if (state_ff == ftws_pkg::BK_RUN) begin
         if (scan_cnt_ff != fill_ff) begin
            scan_cnt_ff  <= scan_cnt_ff + 1'b1;
            scan_pend_ff <= 1'b1;
         end else begin
            scan_pend_ff <= 1'b0;
         end
         if (scan_pend_ff) begin
            if (rd_data_ff != '0 && (min_ff == '0 || rd_data_ff < min_ff)) begin
               min_ff <= rd_data_ff;
            end
            if (rd_data_ff > max_ff) begin
               max_ff <= rd_data_ff;
            end
         end
         if (div_done) begin
            if (!div_fps_ff) begin
               avg_ff <= avg_q;
               if (avg_q != '0) begin
                  div_fps_ff <= 1'b1;
               end else begin
                  fps_ff        <= '0;
                  arith_done_ff <= 1'b1;
               end
            end else begin
               fps_ff        <= div_quo[ftws_pkg::FPS_W-1:0];
               arith_done_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_last_ff <= last_ff;
         rsp_avg_ff  <= avg_ff;
         rsp_fps_ff  <= fps_ff;
         rsp_min_ff  <= min_ff;
         rsp_max_ff  <= max_ff;
         rsp_held_ff <= held_ext[ftws_pkg::HELD_W-1:0];
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.last_frame_us    = rsp_last_ff;
   assign rsp_chan.average_frame_us = rsp_avg_ff;
   assign rsp_chan.fps_q8           = rsp_fps_ff;
   assign rsp_chan.min_frame_us     = rsp_min_ff;
   assign rsp_chan.max_frame_us     = rsp_max_ff;
   assign rsp_chan.samples_held     = rsp_held_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(WINDOW)) else $error("fill count above window size");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !full |-> (slot_ff == fill_ff[IdxW-1:0])) else $error("write slot out of step with fill");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_min_ff <= rsp_max_ff)) else $error("minimum above maximum");

endmodule

FILE: design/frame_time_window_stats_top.sv
// Frame time window statistics: top level.
// req_chan carries timestamp events: command 0 records a frame start, command 1
// ends a frame and stores the elapsed time (modulo 2^32, clamped to 24 bits) in a
// ring of WINDOW samples. Every event yields one item on rsp_chan with the last
// frame time, window average, Q8 frames per second, minimum positive sample,
// maximum sample and the fill count, all taken after the event's update.
// One item is processed at a time by the back end. The serial divider, of width
// DIV_W = max(24 + log2(WINDOW), 28), computes the average and then the fps, one
// bit a cycle, while the window scan reads the single ring read port; with an
// empty window the divides are skipped. The next item enters the back end the
// cycle after a result is loaded.
// Up to two further events queue behind the one in progress; req_chan.ready
// drops only when that queue is full. A result waits in the output register
// while rsp_chan.ready is low, and the back end holds its next result until
// the register frees.
// Reset clears the queue, front, divider, state machine and window state; ring
// entries are only read below the fill count, so no clearing pass is run and items are taken at once.
module frame_time_window_stats_top #(
   parameter int WINDOW = 64
) (
   input  logic       clock,
   input  logic       reset,
   ftws_req_if.sink   req_chan,
   ftws_rsp_if.source rsp_chan
);

   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   ftws_pkg::ftws_op_type push_op;
   ftws_pkg::ftws_op_type head_op;

   ftws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_op     (push_op)
   );

   ftws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (head_op)
   );

   ftws_back #(.WINDOW(WINDOW)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_op     (head_op),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
